[sv/dicom_element_parser_core_assert.svh]
// Assertion macros for the port-level checker of the element parser.
// No dependencies; included by bare file name.
`ifndef DICOM_ELEMENT_PARSER_CORE_ASSERT_SVH
`define DICOM_ELEMENT_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DEP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DEP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/dep_pkg.sv]
// Shared types, codes and decode functions of the element parser.
// No dependencies; used by every RTL file through scoped names.
package dep_pkg;

    // Record kinds.
    typedef enum logic [2:0] {
        KIND_HEADER = 3'd0,
        KIND_VALUE  = 3'd1,
        KIND_DONE   = 3'd2,
        KIND_STOP   = 3'd3,
        KIND_TRUNC  = 3'd4
    } t_kind;

    // Header sizes in bytes.
    localparam logic [3:0] HDR_SHORT = 4'd8;
    localparam logic [3:0] HDR_LONG  = 4'd12;

    // Two-character value representations, first character in the low byte.
    localparam logic [15:0] VR_OB = 16'h424F;
    localparam logic [15:0] VR_OD = 16'h444F;
    localparam logic [15:0] VR_OF = 16'h464F;
    localparam logic [15:0] VR_OL = 16'h4C4F;
    localparam logic [15:0] VR_OV = 16'h564F;
    localparam logic [15:0] VR_OW = 16'h574F;
    localparam logic [15:0] VR_UN = 16'h4E55;
    localparam logic [15:0] VR_SQ = 16'h5153;
    localparam logic [15:0] VR_UC = 16'h4355;
    localparam logic [15:0] VR_UR = 16'h5255;
    localparam logic [15:0] VR_UT = 16'h5455;
    localparam logic [15:0] VR_SS = 16'h5353;
    localparam logic [15:0] VR_US = 16'h5355;
    localparam logic [15:0] VR_SL = 16'h4C53;
    localparam logic [15:0] VR_UL = 16'h4C55;
    localparam logic [15:0] VR_FL = 16'h4C46;
    localparam logic [15:0] VR_FD = 16'h4446;

    // Output queue; the depth must be a power of two so the pointers wrap.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        t_kind        kind;
        logic [31:0]  tag_word;
        logic [15:0]  value_rep;
        logic [31:0]  value_length;
        logic [3:0]   header_bytes;
        logic [7:0]   value_byte;
        logic [63:0]  numeric_value;
        logic         is_numeric;
        logic         last_in_run;
    } t_out_item;

    // Records produced by one accepted byte, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        t_out_item  first;
        t_out_item  second;
    } t_push;

    typedef struct packed {
        logic [3:0] size;
        logic       sgn;
    } t_num_info;

    function automatic logic [3:0] header_size(logic [15:0] vr, logic long_text);
        logic [3:0] hs;
        unique case (vr) inside
            VR_OB, VR_OD, VR_OF, VR_OL, VR_OV, VR_OW, VR_UN, VR_SQ: hs = HDR_LONG;
            VR_UC, VR_UR, VR_UT: hs = long_text ? HDR_LONG : HDR_SHORT;
            default: hs = HDR_SHORT;
        endcase
        return hs;
    endfunction

    function automatic t_num_info numeric_info(logic [15:0] vr);
        t_num_info ni;
        unique case (vr)
            VR_SS:   ni = '{size: 4'd2, sgn: 1'b1};
            VR_US:   ni = '{size: 4'd2, sgn: 1'b0};
            VR_SL:   ni = '{size: 4'd4, sgn: 1'b1};
            VR_UL:   ni = '{size: 4'd4, sgn: 1'b0};
            VR_FL:   ni = '{size: 4'd4, sgn: 1'b0};
            VR_FD:   ni = '{size: 4'd8, sgn: 1'b0};
            default: ni = '{size: 4'd0, sgn: 1'b0};
        endcase
        return ni;
    endfunction

    // First value of a numeric element; zero for other VRs or a value too short.
    function automatic logic [63:0] numeric_result(logic [15:0] vr, logic [31:0] len,
                                                   logic [63:0] acc);
        t_num_info  ni;
        logic [63:0] v;
        ni = numeric_info(vr);
        if (ni.size == 4'd0 || len < {28'd0, ni.size}) begin
            v = 64'd0;
        end else begin
            case (ni.size)
                4'd2:    v = {{48{acc[15] & ni.sgn}}, acc[15:0]};
                4'd4:    v = {{32{acc[31] & ni.sgn}}, acc[31:0]};
                default: v = acc;
            endcase
        end
        return v;
    endfunction

    function automatic t_out_item make_record(t_kind kind, logic [31:0] tag,
                                              logic [15:0] vr, logic [31:0] len,
                                              logic known, logic long_text,
                                              logic [7:0] vbyte, logic [63:0] num);
        t_out_item r;
        t_num_info ni;
        ni              = numeric_info(vr);
        r.kind          = kind;
        r.tag_word      = tag;
        r.value_rep     = vr;
        r.value_length  = len;
        r.header_bytes  = known ? header_size(vr, long_text) : 4'd0;
        r.value_byte    = vbyte;
        r.numeric_value = num;
        r.is_numeric    = known && (ni.size != 4'd0);
        r.last_in_run   = 1'b0;
        return r;
    endfunction

endpackage

[sv/dep_parse.sv]
// Per-byte parser state machine and record builder of the element parser.
// Depends on dep_pkg.
module dep_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  dep_pkg::t_in_item i_item,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    output dep_pkg::t_push    o_push
);

    typedef enum logic {
        PH_HEADER,
        PH_VALUE
    } t_phase;

    t_phase      r_phase,   n_phase,   m_phase;
    logic [3:0]  r_hcnt,    n_hcnt,    m_hcnt;
    logic [31:0] r_tag,     n_tag,     m_tag;
    logic [15:0] r_vr,      n_vr,      m_vr;
    logic [31:0] r_len,     n_len,     m_len;
    logic [31:0] r_rem,     n_rem,     m_rem;
    logic [63:0] r_acc,     n_acc,     m_acc;
    logic [3:0]  r_vidx,    n_vidx,    m_vidx;
    logic        r_stopped, n_stopped, m_stopped;
    logic        r_long_text;

    logic [7:0]         b;
    logic [3:0]         hs;
    logic               boundary;
    logic               mid_elem;
    logic [1:0]         nrec;
    dep_pkg::t_out_item rec0, rec1;

    assign b = i_item.data_byte;

    always_comb begin
        m_phase   = r_phase;
        m_hcnt    = r_hcnt;
        m_tag     = r_tag;
        m_vr      = r_vr;
        m_len     = r_len;
        m_rem     = r_rem;
        m_acc     = r_acc;
        m_vidx    = r_vidx;
        m_stopped = r_stopped;
        hs        = dep_pkg::HDR_SHORT;
        boundary  = 1'b0;
        nrec      = 2'd0;
        rec0      = '0;
        rec1      = '0;

        if (r_stopped) begin
            boundary = 1'b1;
        end else if (r_phase == PH_HEADER) begin
            if (r_hcnt == 4'd0) begin
                m_tag  = '0;
                m_vr   = '0;
                m_len  = '0;
                m_rem  = '0;
                m_acc  = '0;
                m_vidx = '0;
            end
            if (r_hcnt < 4'd4) begin
                m_tag[{r_hcnt[1:0], 3'b000} +: 8] = b;
            end else if (r_hcnt < 4'd6) begin
                m_vr[{r_hcnt[0], 3'b000} +: 8] = b;
            end
            hs = dep_pkg::header_size(m_vr, r_long_text);
            if (r_hcnt >= 4'd6) begin
                if (hs == dep_pkg::HDR_SHORT) begin
                    m_len[{r_hcnt[1:0] - 2'd2, 3'b000} +: 8] = b;
                end else if (r_hcnt >= 4'd8) begin
                    m_len[{r_hcnt[1:0], 3'b000} +: 8] = b;
                end
            end
            m_hcnt = r_hcnt + 4'd1;
            if (r_hcnt == 4'd3 && m_tag == 32'd0) begin
                nrec      = 2'd1;
                rec0      = dep_pkg::make_record(dep_pkg::KIND_STOP, m_tag, m_vr, m_len,
                                                 1'b0, r_long_text, 8'd0, 64'd0);
                m_stopped = 1'b1;
                boundary  = 1'b1;
            end else if (r_hcnt >= 4'd6 && m_hcnt == hs) begin
                // The header record goes out before the phase moves on, so the
                // representation still reads as unknown in it.
                m_hcnt = 4'd0;
                nrec   = 2'd1;
                rec0   = dep_pkg::make_record(dep_pkg::KIND_HEADER, m_tag, m_vr, m_len,
                                              1'b0, r_long_text, 8'd0, 64'd0);
                if (m_len == 32'd0) begin
                    nrec     = 2'd2;
                    rec1     = dep_pkg::make_record(dep_pkg::KIND_DONE, m_tag, m_vr, m_len,
                                                    1'b0, r_long_text, 8'd0,
                                                    dep_pkg::numeric_result(m_vr, m_len,
                                                                            m_acc));
                    boundary = 1'b1;
                end else begin
                    m_phase = PH_VALUE;
                    m_rem   = m_len;
                end
            end
        end else begin
            if (r_vidx < 4'd8) begin
                m_acc[{r_vidx[2:0], 3'b000} +: 8] = b;
                m_vidx = r_vidx + 4'd1;
            end
            m_rem = r_rem - 32'd1;
            nrec  = 2'd1;
            rec0  = dep_pkg::make_record(dep_pkg::KIND_VALUE, m_tag, m_vr, m_len,
                                         1'b1, r_long_text, b, 64'd0);
            if (m_rem == 32'd0) begin
                nrec     = 2'd2;
                rec1     = dep_pkg::make_record(dep_pkg::KIND_DONE, m_tag, m_vr, m_len,
                                                1'b1, r_long_text, 8'd0,
                                                dep_pkg::numeric_result(m_vr, m_len, m_acc));
                m_phase  = PH_HEADER;
                m_hcnt   = 4'd0;
                boundary = 1'b1;
            end
        end

        // A buffer that ends inside an element appends a truncation record.
        mid_elem = !boundary && !(m_phase == PH_HEADER && m_hcnt == 4'd0);
        if (i_item.end_of_buffer && mid_elem && nrec != 2'd2) begin
            if (nrec == 2'd0) begin
                rec0 = dep_pkg::make_record(dep_pkg::KIND_TRUNC, m_tag, m_vr, m_len,
                                            (m_phase == PH_VALUE) || (m_hcnt >= 4'd6),
                                            r_long_text, 8'd0, 64'd0);
            end else begin
                rec1 = dep_pkg::make_record(dep_pkg::KIND_TRUNC, m_tag, m_vr, m_len,
                                            (m_phase == PH_VALUE) || (m_hcnt >= 4'd6),
                                            r_long_text, 8'd0, 64'd0);
            end
            nrec = nrec + 2'd1;
        end

        if (nrec == 2'd1) begin
            rec0.last_in_run = 1'b1;
        end else if (nrec == 2'd2) begin
            rec1.last_in_run = 1'b1;
        end

        if (i_item.end_of_buffer) begin
            n_phase   = PH_HEADER;
            n_hcnt    = '0;
            n_tag     = '0;
            n_vr      = '0;
            n_len     = '0;
            n_rem     = '0;
            n_acc     = '0;
            n_vidx    = '0;
            n_stopped = 1'b0;
        end else begin
            n_phase   = m_phase;
            n_hcnt    = m_hcnt;
            n_tag     = m_tag;
            n_vr      = m_vr;
            n_len     = m_len;
            n_rem     = m_rem;
            n_acc     = m_acc;
            n_vidx    = m_vidx;
            n_stopped = m_stopped;
        end

        o_push.count  = i_accept ? nrec : 2'd0;
        o_push.first  = rec0;
        o_push.second = rec1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hcnt      <= '0;
            r_tag       <= '0;
            r_vr        <= '0;
            r_len       <= '0;
            r_rem       <= '0;
            r_acc       <= '0;
            r_vidx      <= '0;
            r_stopped   <= 1'b0;
            r_long_text <= 1'b1;
        end else begin
            if (i_accept) begin
                r_phase   <= n_phase;
                r_hcnt    <= n_hcnt;
                r_tag     <= n_tag;
                r_vr      <= n_vr;
                r_len     <= n_len;
                r_rem     <= n_rem;
                r_acc     <= n_acc;
                r_vidx    <= n_vidx;
                r_stopped <= n_stopped;
            end
            if (i_cfg_we) begin
                r_long_text <= i_cfg_wdata;
            end
        end
    end

endmodule

[sv/dep_queue.sv]
// Small record queue that takes up to two records per cycle and hands out one.
// Depends on dep_pkg.
module dep_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dep_pkg::t_push     i_push,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_ready,
    output dep_pkg::t_out_item o_data
);

    dep_pkg::t_out_item r_mem [dep_pkg::QUEUE_DEPTH];

    logic [dep_pkg::QUEUE_AW-1:0] r_wr, r_rd, wr_next;
    logic [dep_pkg::QUEUE_CW-1:0] r_count;
    logic                         pop;

    assign pop     = (r_count != '0) && i_ready;
    assign wr_next = r_wr + dep_pkg::QUEUE_AW'(1);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_room  = r_count <= dep_pkg::QUEUE_CW'(dep_pkg::QUEUE_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + dep_pkg::QUEUE_AW'(i_push.count);
            r_rd    <= r_rd + dep_pkg::QUEUE_AW'(pop);
            r_count <= r_count + dep_pkg::QUEUE_CW'(i_push.count)
                       - dep_pkg::QUEUE_CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.second;
        end
    end

endmodule

[sv/dicom_element_parser_core.sv]
// Top level of the explicit-VR little-endian element parser.
// Depends on dep_pkg, dep_parse and dep_queue.
//
// The block takes an encoded element stream one byte per transfer on the input
// channel (i_in_valid / o_in_ready, payload i_in_data) and delivers records on
// the output channel (o_out_valid / i_out_ready, payload o_out_data). Each byte
// causes zero, one or two records; the last record of a byte has last_in_run
// set. Per element the records are a header record, one record per value byte
// and a done record, which carries the first numeric value for SS, US, SL, UL,
// FL and FD. A zero tag gives a stop record and silences the parser until the
// byte flagged end_of_buffer; a buffer that ends inside an element gives a
// truncation record. After any end_of_buffer byte the parser starts afresh.
//
// The records of a byte are registered into the output queue at its transfer.
// The parser accepts one byte per cycle while the queue has room; the output
// delivers one record per cycle while the receiver is ready. The output rate is
// set by the single read port of the four-entry output queue.
//
// The input is ready while the queue has room for two records, so a stalled
// receiver backs up into the input once three records wait; nothing is dropped.
// Reset clears the parser state and the queue and sets the configuration bit
// (UC, UR, UT take the long header) to one; i_cfg_we writes i_cfg_wdata into it.
module dicom_element_parser_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dep_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dep_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata
);

    logic           accept;
    dep_pkg::t_push push;

    // A byte is taken only when the queue can hold every record it may cause.
    assign accept = i_in_valid && o_in_ready;

    dep_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_push      (push)
    );

    // The queue registers the records and parts the two channels.
    dep_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

[sv/dep_checker.sv]
// Port-level checker of the element parser, bound to the top level.
// Depends on dep_pkg and dicom_element_parser_core_assert.svh.
`include "dicom_element_parser_core_assert.svh"

module dep_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input dep_pkg::t_out_item i_out_data
);

    `DEP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "output record changed while stalled")
    `DEP_ASSERT_IMPLY(a_value_hdr_known, i_clk, i_rst_n, i_out_valid && i_out_data.kind == dep_pkg::KIND_VALUE, i_out_data.header_bytes == dep_pkg::HDR_SHORT || i_out_data.header_bytes == dep_pkg::HDR_LONG, "value record without a known header size")
    `DEP_ASSERT_IMPLY(a_vbyte_zero, i_clk, i_rst_n, i_out_valid && i_out_data.kind != dep_pkg::KIND_VALUE, i_out_data.value_byte == 8'd0, "value byte set outside a value record")
    `DEP_ASSERT_IMPLY(a_num_zero, i_clk, i_rst_n, i_out_valid && i_out_data.kind != dep_pkg::KIND_DONE, i_out_data.numeric_value == 64'd0, "numeric value set outside a done record")

endmodule

bind dicom_element_parser_core dep_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

[test/dep_record_checker.sv]
// Checker for the element parser: watches both channels and the config port,
// predicts the records of every byte and compares them in order. Needs dep_pkg.
module dep_record_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  dep_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  dep_pkg::t_out_item i_out_data,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    output int unsigned        o_mismatches,
    output int unsigned        o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import dep_pkg::*;

    t_out_item   due_records[$];
    int unsigned mismatches = 0;
    int unsigned outstanding = 0;

    // Copy of the configuration bit and of the parser state.
    logic        long_text = 1'b1;
    logic        in_value;
    logic [3:0]  hdr_count;
    logic [31:0] tag_acc;
    logic [15:0] vr_acc;
    logic [31:0] len_acc;
    logic [31:0] left;
    logic [63:0] num_acc;
    logic        halted;

    assign o_mismatches  = mismatches;
    assign o_outstanding = outstanding;

    function automatic logic [3:0] hdr_size_of(logic [15:0] vr);
        case (vr)
            VR_OB, VR_OD, VR_OF, VR_OL, VR_OV, VR_OW, VR_UN, VR_SQ: return HDR_LONG;
            VR_UC, VR_UR, VR_UT: return long_text ? HDR_LONG : HDR_SHORT;
            default: return HDR_SHORT;
        endcase
    endfunction

    function automatic logic [3:0] num_bytes(logic [15:0] vr);
        case (vr)
            VR_SS, VR_US:        return 4'd2;
            VR_SL, VR_UL, VR_FL: return 4'd4;
            VR_FD:               return 4'd8;
            default:             return 4'd0;
        endcase
    endfunction

    function automatic logic [63:0] first_value();
        logic [3:0] n;
        logic       sgn;
        n   = num_bytes(vr_acc);
        sgn = (vr_acc == VR_SS) || (vr_acc == VR_SL);
        if (n == 4'd0 || len_acc < {28'd0, n}) return 64'd0;
        case (n)
            4'd2:    return {{48{sgn & num_acc[15]}}, num_acc[15:0]};
            4'd4:    return {{32{sgn & num_acc[31]}}, num_acc[31:0]};
            default: return num_acc;
        endcase
    endfunction

    // A record as the parser state stands at this moment.
    function automatic t_out_item snapshot(t_kind k, logic [7:0] vb, logic [63:0] num);
        t_out_item r;
        logic      known;
        known           = in_value || (hdr_count >= 4'd6);
        r.kind          = k;
        r.tag_word      = tag_acc;
        r.value_rep     = vr_acc;
        r.value_length  = len_acc;
        r.header_bytes  = known ? hdr_size_of(vr_acc) : 4'd0;
        r.value_byte    = vb;
        r.numeric_value = num;
        r.is_numeric    = known && (num_bytes(vr_acc) != 4'd0);
        r.last_in_run   = 1'b0;
        return r;
    endfunction

    task automatic clear_parse();
        in_value  = 1'b0;
        hdr_count = 4'd0;
        tag_acc   = '0;
        vr_acc    = '0;
        len_acc   = '0;
        left      = '0;
        num_acc   = '0;
        halted    = 1'b0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic eob);
        t_out_item   batch[$];
        logic [3:0]  c;
        logic [31:0] idx;
        logic        at_boundary;
        logic        mid_element;
        at_boundary = 1'b0;
        if (halted) begin
            at_boundary = 1'b1;
        end else if (!in_value) begin
            c = hdr_count;
            if (c == 4'd0) begin
                tag_acc = '0;
                vr_acc  = '0;
                len_acc = '0;
                left    = '0;
                num_acc = '0;
            end
            if (c < 4'd4) begin
                tag_acc[8*c +: 8] = b;
            end else if (c < 4'd6) begin
                vr_acc[8*(c-4) +: 8] = b;
            end else if (hdr_size_of(vr_acc) == HDR_SHORT) begin
                len_acc[8*(c-6) +: 8] = b;
            end else if (c >= 4'd8) begin
                len_acc[8*(c-8) +: 8] = b;
            end
            hdr_count = c + 4'd1;
            if (c == 4'd3 && tag_acc == '0) begin
                batch.push_back(snapshot(KIND_STOP, 8'd0, 64'd0));
                halted      = 1'b1;
                at_boundary = 1'b1;
            end else if (c >= 4'd6 && hdr_count == hdr_size_of(vr_acc)) begin
                // The count is cleared before the header record is formed.
                hdr_count = 4'd0;
                batch.push_back(snapshot(KIND_HEADER, 8'd0, 64'd0));
                if (len_acc == '0) begin
                    batch.push_back(snapshot(KIND_DONE, 8'd0, first_value()));
                    at_boundary = 1'b1;
                end else begin
                    in_value = 1'b1;
                    left     = len_acc;
                end
            end
        end else begin
            idx = len_acc - left;
            if (idx < 32'd8) num_acc[8*idx[2:0] +: 8] = b;
            left = left - 32'd1;
            batch.push_back(snapshot(KIND_VALUE, b, 64'd0));
            if (left == '0) begin
                batch.push_back(snapshot(KIND_DONE, 8'd0, first_value()));
                in_value    = 1'b0;
                hdr_count   = 4'd0;
                at_boundary = 1'b1;
            end
        end
        if (eob) begin
            mid_element = !at_boundary && !(!in_value && hdr_count == 4'd0);
            if (mid_element && batch.size() < 2)
                batch.push_back(snapshot(KIND_TRUNC, 8'd0, 64'd0));
            clear_parse();
        end
        if (batch.size() > 0) batch[batch.size()-1].last_in_run = 1'b1;
        foreach (batch[i]) due_records.push_back(batch[i]);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_record(input t_out_item want, input t_out_item got);
        check_field("kind", 64'(want.kind), 64'(got.kind));
        check_field("tag_word", 64'(want.tag_word), 64'(got.tag_word));
        check_field("value_rep", 64'(want.value_rep), 64'(got.value_rep));
        check_field("value_length", 64'(want.value_length), 64'(got.value_length));
        check_field("header_bytes", 64'(want.header_bytes), 64'(got.header_bytes));
        check_field("value_byte", 64'(want.value_byte), 64'(got.value_byte));
        check_field("numeric_value", want.numeric_value, got.numeric_value);
        check_field("is_numeric", 64'(want.is_numeric), 64'(got.is_numeric));
        check_field("last_in_run", 64'(want.last_in_run), 64'(got.last_in_run));
    endtask

    initial clear_parse();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            long_text = 1'b1;
            due_records.delete();
        end else begin
            // A byte's records are registered, so retire before predicting.
            if (i_out_valid && i_out_ready) begin
                if (due_records.size() == 0) begin
                    $error("record with nothing expected: kind %0d tag %08h",
                           i_out_data.kind, i_out_data.tag_word);
                    mismatches++;
                end else begin
                    compare_record(due_records.pop_front(), i_out_data);
                end
            end
            if (i_in_valid && i_in_ready)
                parse_byte(i_in_data.data_byte, i_in_data.end_of_buffer);
            if (i_cfg_we) long_text = i_cfg_wdata;
        end
        outstanding = due_records.size();
    end

endmodule

[test/dicom_element_parser_core_tb.sv]
// Testbench top for dicom_element_parser_core: clock, reset, byte stream and
// receiver stimulus, and the verdict. Needs dep_pkg, the RTL and dep_record_checker.
module dicom_element_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dep_pkg::*;

    // A run with no transfer on either channel for this many cycles is hung.
    localparam int STALL_LIMIT = 1000;
    // Length of the one long receiver hold-off that backs the block up.
    localparam int HOLD_CYCLES = 120;
    // Long string, a text VR that always takes the short header.
    localparam logic [15:0] VR_LO = 16'h4F4C;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_data;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    int unsigned mismatches;
    int unsigned outstanding;

    // Stimulus-side view of the configuration, used to lay out headers.
    bit cfg_long = 1'b1;
    // Set near the end of the run; both sides stop idling from then on.
    bit calm = 1'b0;
    // Asks the receiver for its one long hold-off.
    bit hold_req = 1'b0;
    int bytes_sent = 0;
    int idle_cycles = 0;

    logic [15:0] vr_pool [17] = '{VR_OB, VR_OD, VR_OF, VR_OL, VR_OV, VR_OW, VR_UN,
                                  VR_SQ, VR_UC, VR_UR, VR_UT, VR_SS, VR_US, VR_SL,
                                  VR_UL, VR_FL, VR_FD};

    always #5 clk = ~clk;

    dicom_element_parser_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    dep_record_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Whether the stream must carry the 12-byte header for this VR.
    function automatic bit long_form(logic [15:0] vr);
        case (vr)
            VR_OB, VR_OD, VR_OF, VR_OL, VR_OV, VR_OW, VR_UN, VR_SQ: return 1'b1;
            VR_UC, VR_UR, VR_UT: return cfg_long;
            default: return 1'b0;
        endcase
    endfunction

    // Byte i of an element header; the two reserved bytes are random.
    function automatic logic [7:0] header_byte(int i, logic [31:0] tag, logic [15:0] vr,
                                               logic [31:0] len, bit long_hdr);
        if (i < 4) return tag[8*i +: 8];
        if (i < 6) return vr[8*(i-4) +: 8];
        if (!long_hdr) return len[8*(i-6) +: 8];
        if (i < 8) return 8'($urandom);
        return len[8*(i-8) +: 8];
    endfunction

    // Offers one byte and returns at the falling edge after its transfer.
    // Valid is left high so the next byte can follow without a bubble.
    task automatic send_byte(input logic [7:0] b, input logic eob);
        bit taken;
        if (!calm && $urandom_range(0, 7) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_data  = '{data_byte: b, end_of_buffer: eob};
        in_valid = 1'b1;
        taken = 1'b0;
        while (!taken) begin
            @(posedge clk);
            taken = in_ready;
            @(negedge clk);
        end
        bytes_sent++;
    endtask

    // Sends one element. A cut at or past the end of the element is ignored;
    // otherwise the buffer ends on byte number cut. fill < 0 gives random value
    // bytes, anything else a constant byte. Only the bytes up to the cut are
    // built, so huge declared lengths cost nothing.
    task automatic send_element(input logic [31:0] tag, input logic [15:0] vr,
                                input logic [31:0] len, input longint cut,
                                input bit eob_last, input int fill);
        bit         long_hdr;
        int         hdr;
        longint     total;
        longint     last_idx;
        bit         eob_at_end;
        logic [7:0] b;
        long_hdr = long_form(vr);
        hdr      = long_hdr ? 12 : 8;
        total    = hdr + longint'({32'd0, len});
        if (cut >= 0 && cut < total) begin
            last_idx   = cut;
            eob_at_end = 1'b1;
        end else begin
            last_idx   = total - 1;
            eob_at_end = eob_last;
        end
        for (longint i = 0; i <= last_idx; i++) begin
            if (i < hdr) b = header_byte(int'(i), tag, vr, len, long_hdr);
            else if (fill < 0) b = 8'($urandom);
            else b = 8'(fill);
            send_byte(b, eob_at_end && (i == last_idx));
        end
    endtask

    // A zero tag, then junk bytes the parser must swallow, then the end of
    // the buffer. With no junk the buffer ends on the stopping byte itself.
    task automatic stop_run(input int junk);
        for (int k = 0; k < 4; k++) send_byte(8'h00, (junk == 0) && (k == 3));
        for (int k = 0; k < junk; k++) send_byte(8'($urandom), k == junk - 1);
    endtask

    // The register is only touched with the block drained and quiet. A byte
    // that causes no record may still be in flight, hence the extra cycles.
    task automatic write_long_text(input bit v);
        in_valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we   = 1'b0;
        cfg_long = v;
    endtask

    // One random element. Most are well formed with small lengths so that
    // every VR completes often; some use noise VRs, cut buffers, huge lengths
    // with a cut near the header, or zero tags.
    task automatic random_element();
        logic [31:0] tag;
        logic [15:0] vr;
        logic [31:0] len;
        bit          huge;
        int          hdr;
        longint      cut;
        int          fill;
        if ($urandom_range(0, 99) < 4) begin
            stop_run($urandom_range(0, 4));
        end else begin
            tag = $urandom;
            if (tag == '0) tag = 32'h1;
            if ($urandom_range(0, 9) == 0) vr = 16'($urandom);
            else vr = vr_pool[$urandom_range(0, 16)];
            hdr  = long_form(vr) ? 12 : 8;
            huge = 1'b0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(0, 8);
                6, 7:             len = $urandom_range(9, 24);
                8:                len = $urandom_range(25, 60);
                default: begin
                    huge = 1'b1;
                    len  = (hdr == 12) ? $urandom : $urandom_range(0, 65535);
                end
            endcase
            if (huge) cut = $urandom_range(0, hdr + 20);
            else if ($urandom_range(0, 11) == 0) cut = $urandom_range(0, hdr + len);
            else cut = -1;
            if ($urandom_range(0, 7) == 0) fill = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else fill = -1;
            send_element(tag, vr, len, cut, $urandom_range(0, 9) == 0, fill);
        end
    endtask

    // Receiver: random stall bursts, one long hold-off on request, and no
    // stalls at all once the run has gone calm.
    initial begin
        bit held;
        held = 1'b0;
        @(negedge clk);
        forever begin
            if (hold_req && !held) begin
                held      = 1'b1;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end else begin
                out_ready = 1'b1;
                @(negedge clk);
            end
        end
    end

    // Watchdog: ends the run when neither channel has moved for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int start;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed cases with the register at its reset value (long text VRs).
        send_element(32'h0010_0010, VR_US, 32'd2, -1, 1'b0, -1);
        send_element(32'h0028_0030, VR_SS, 32'd2, -1, 1'b0, 8'hFF);   // -1 sign-extended
        send_element(32'h7FE0_0010, VR_OB, 32'd0, -1, 1'b0, -1);      // header and done at once
        send_element(32'hFFFF_FFFF, VR_SQ, 32'd3, -1, 1'b0, 8'h00);
        send_element(32'h0018_0050, VR_SL, 32'd2, -1, 1'b0, -1);      // too short for its type
        send_element(32'h0018_0060, VR_FD, 32'd9, -1, 1'b0, 8'hFF);   // ninth byte not kept
        send_element(32'h0020_0013, VR_UL, 32'd4, -1, 1'b1, 8'h00);   // buffer ends on last byte
        send_element(32'h0042_0011, VR_UN, 32'hFFFF_FFFF, 14, 1'b0, -1);
        send_element(32'h0008_0016, VR_FL, 32'd4, 0, 1'b0, -1);       // buffer ends on first byte
        send_element(32'h0008_0018, VR_OW, 32'd4, 5, 1'b0, -1);       // ends on the last VR byte
        stop_run(3);
        stop_run(0);
        send_element(32'h0008_0119, VR_UC, 32'd2, -1, 1'b0, -1);

        // Text VRs with the short header as the file has it.
        write_long_text(1'b0);
        send_element(32'h0008_0119, VR_UT, 32'd2, -1, 1'b0, -1);
        send_element(32'h0008_0120, VR_UC, 32'd0, -1, 1'b0, -1);
        send_element(32'h0008_0121, VR_UR, 32'd1, -1, 1'b0, -1);
        send_element(32'h0008_0122, VR_LO, 32'hFFFF, 10, 1'b0, -1);
        write_long_text(1'b1);
        send_element(32'h0008_0123, VR_UT, 32'd2, -1, 1'b0, -1);

        // Random part in three passes: register cleared, set, cleared again. The long
        // receiver hold-off falls at the start, and the last stretch runs with no idling.
        for (int p = 0; p < 3; p++) begin
            write_long_text(p == 1);
            if (p == 0) hold_req = 1'b1;
            start = bytes_sent;
            while (bytes_sent - start < 90) begin
                if (p == 2 && bytes_sent - start >= 45) calm = 1'b1;
                random_element();
            end
        end

        in_valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
